### hdl/olid_pkg.sv
package olid_pkg;

   // Default number of list entries.
   localparam int DEPTH_DEFAULT = 128;

   // Operation codes carried in the opcode field.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOCATE = 2'd2;
   // Spare code: leaves the list alone and reports the length.
   localparam logic [1:0] OP_NOP    = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_POS   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // One operation as it arrives on the request channel.
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] position;
      logic [7:0] value;
   } req_type;

   // One result as it leaves on the response channel.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] removed_value;
      logic [7:0] found_position;
      logic [7:0] list_length;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_TEST,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_TAKE,
      S_DEL_KEEP,
      S_DEL_TEST,
      S_DEL_RD,
      S_DEL_WR,
      S_DEL_END,
      S_LOC_RD,
      S_LOC_CMP,
      S_FINISH
   } state_type;

   // Datapath commands issued by the controller.
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_DECODE,
      CMD_READ_IDX,
      CMD_READ_PREV,
      CMD_READ_NEXT,
      CMD_SHIFT_UP,
      CMD_SHIFT_DOWN,
      CMD_PUT,
      CMD_KEEP,
      CMD_DROP,
      CMD_COMPARE,
      CMD_EMIT
   } cmd_type;

   // Controller to datapath.
   typedef struct packed {
      cmd_type cmd;
      logic    req_open;
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic ins_go;
      logic del_go;
      logic loc_go;
      logic ins_more;
      logic del_more;
      logic loc_hit;
      logic loc_last;
      logic rsp_free;
   } sts_type;

endpackage

### hdl/olid_ram.sv
module olid_ram import olid_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/olid_ctrl.sv
module olid_ctrl import olid_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.ins_go) begin
               state_in = S_INS_TEST;
            end else if (sts.del_go) begin
               state_in = S_DEL_TAKE;
            end else if (sts.loc_go) begin
               state_in = S_LOC_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_INS_TEST: begin
            state_in = sts.ins_more ? S_INS_RD : S_INS_PUT;
         end
         S_INS_RD:   state_in = S_INS_WR;
         S_INS_WR:   state_in = S_INS_TEST;
         S_INS_PUT:  state_in = S_FINISH;
         S_DEL_TAKE: state_in = S_DEL_KEEP;
         S_DEL_KEEP: state_in = S_DEL_TEST;
         S_DEL_TEST: begin
            state_in = sts.del_more ? S_DEL_RD : S_DEL_END;
         end
         S_DEL_RD:   state_in = S_DEL_WR;
         S_DEL_WR:   state_in = S_DEL_TEST;
         S_DEL_END:  state_in = S_FINISH;
         S_LOC_RD:   state_in = S_LOC_CMP;
         S_LOC_CMP: begin
            if (sts.loc_hit || sts.loc_last) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_LOC_RD;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands for each state.
   always_comb begin
      ctl.cmd      = CMD_NONE;
      ctl.req_open = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ctl.req_open = 1'b1;
            if (req_valid) begin
               ctl.cmd = CMD_ACCEPT;
            end
         end
         S_DECODE:   ctl.cmd = CMD_DECODE;
         S_INS_TEST: ctl.cmd = CMD_NONE;
         S_INS_RD:   ctl.cmd = CMD_READ_PREV;
         S_INS_WR:   ctl.cmd = CMD_SHIFT_UP;
         S_INS_PUT:  ctl.cmd = CMD_PUT;
         S_DEL_TAKE: ctl.cmd = CMD_READ_IDX;
         S_DEL_KEEP: ctl.cmd = CMD_KEEP;
         S_DEL_TEST: ctl.cmd = CMD_NONE;
         S_DEL_RD:   ctl.cmd = CMD_READ_NEXT;
         S_DEL_WR:   ctl.cmd = CMD_SHIFT_DOWN;
         S_DEL_END:  ctl.cmd = CMD_DROP;
         S_LOC_RD:   ctl.cmd = CMD_READ_IDX;
         S_LOC_CMP:  ctl.cmd = CMD_COMPARE;
         S_FINISH: begin
            if (sts.rsp_free) begin
               ctl.cmd = CMD_EMIT;
            end
         end
         default: ctl.cmd = CMD_NONE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/olid_dpath.sv
module olid_dpath import olid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl,
   output sts_type sts,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;

   // Operation held for the whole of its run.
   logic [1:0]       op_ff,      op_in;
   logic [7:0]       pos_ff,     pos_in;
   logic [7:0]       val_ff,     val_in;
   // List length and the walking entry index.
   logic [CNT_W-1:0] cnt_ff,     cnt_in;
   logic [CNT_W-1:0] idx_ff,     idx_in;
   // Result being built.
   logic [1:0]       status_ff,  status_in;
   logic [7:0]       removed_ff, removed_in;
   logic [CNT_W-1:0] found_ff,   found_in;
   // Output register.
   rsp_type          rsp_ff,     rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [7:0]        ram_wd;
   logic [ADDR_W-1:0] ram_ra;
   logic [7:0]        ram_rd;

   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] idx_w;
   logic [CMP_W-1:0] pos_m1;
   logic [CNT_W-1:0] idx_prev;
   logic [CNT_W-1:0] idx_next;
   logic [CMP_W-1:0] found_w;
   logic             ins_bad;
   logic             ins_full;
   logic             del_bad;

   olid_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Widened copies so that position and length compare without overflow.
   assign pos_w    = CMP_W'(pos_ff);
   assign cnt_w    = CMP_W'(cnt_ff);
   assign idx_w    = CMP_W'(idx_ff);
   assign pos_m1   = pos_w - CMP_W'(1);
   assign idx_prev = idx_ff - CNT_W'(1);
   assign idx_next = idx_ff + CNT_W'(1);
   assign found_w  = CMP_W'(found_ff);

   // Position checks for the held operation.
   assign ins_bad  = (pos_ff == 8'd0) || (pos_w > (cnt_w + CMP_W'(1)));
   assign ins_full = (cnt_w >= CMP_W'(DEPTH));
   assign del_bad  = (pos_ff == 8'd0) || (pos_w > cnt_w);

   // Status towards the controller.
   always_comb begin
      sts.ins_go   = (op_ff == OP_INSERT) && !ins_bad && !ins_full;
      sts.del_go   = (op_ff == OP_DELETE) && !del_bad;
      sts.loc_go   = (op_ff == OP_LOCATE) && (cnt_ff != '0);
      sts.ins_more = (idx_w >= pos_w);
      sts.del_more = (CMP_W'(idx_next) < cnt_w);
      sts.loc_hit  = (ram_rd == val_ff);
      sts.loc_last = (CMP_W'(idx_next) >= cnt_w);
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   // Command decode: register updates and memory accesses.
   always_comb begin
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_wa       = idx_ff[ADDR_W-1:0];
      ram_wd       = ram_rd;
      ram_ra       = idx_ff[ADDR_W-1:0];
      unique case (ctl.cmd)
         CMD_NONE: begin
         end
         CMD_ACCEPT: begin
            op_in      = req_data.opcode;
            pos_in     = req_data.position;
            val_in     = req_data.value;
            status_in  = ST_OK;
            removed_in = 8'd0;
            found_in   = '0;
         end
         CMD_DECODE: begin
            case (op_ff)
               OP_INSERT: begin
                  if (ins_bad) begin
                     status_in = ST_BAD_POS;
                  end else if (ins_full) begin
                     status_in = ST_FULL;
                  end else begin
                     idx_in = cnt_ff;
                  end
               end
               OP_DELETE: begin
                  if (del_bad) begin
                     status_in = ST_BAD_POS;
                  end else begin
                     idx_in = pos_m1[CNT_W-1:0];
                  end
               end
               OP_LOCATE: begin
                  status_in = ST_NOT_FOUND;
                  idx_in    = '0;
               end
               default: begin
               end
            endcase
         end
         CMD_READ_IDX: begin
            ram_ra = idx_ff[ADDR_W-1:0];
         end
         CMD_READ_PREV: begin
            ram_ra = idx_prev[ADDR_W-1:0];
         end
         CMD_READ_NEXT: begin
            ram_ra = idx_next[ADDR_W-1:0];
         end
         CMD_SHIFT_UP: begin
            ram_we = 1'b1;
            ram_wa = idx_ff[ADDR_W-1:0];
            ram_wd = ram_rd;
            idx_in = idx_prev;
         end
         CMD_SHIFT_DOWN: begin
            ram_we = 1'b1;
            ram_wa = idx_ff[ADDR_W-1:0];
            ram_wd = ram_rd;
            idx_in = idx_next;
         end
         CMD_PUT: begin
            ram_we = 1'b1;
            ram_wa = pos_m1[ADDR_W-1:0];
            ram_wd = val_ff;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         CMD_KEEP: begin
            removed_in = ram_rd;
         end
         CMD_DROP: begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
         CMD_COMPARE: begin
            if (ram_rd == val_ff) begin
               found_in  = idx_next;
               status_in = ST_OK;
            end else begin
               idx_in = idx_next;
            end
         end
         CMD_EMIT: begin
            rsp_in.status         = status_ff;
            rsp_in.removed_value  = removed_ff;
            rsp_in.found_position = found_w[7:0];
            rsp_in.list_length    = cnt_w[7:0];
            rsp_valid_in          = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/ordered_list_insert_delete_top.sv
// Ordered byte list with insert, delete and locate operations.
// Request channel (req_valid, req_stall, req_data): one operation per transfer,
// taken only while the block is idle; req_stall is high while an operation runs.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one result per
// operation, held in an output register until the receiver takes it.
// Entries live in a single-port-read, single-port-write RAM with registered
// read, so every moved entry passes through a read state, a write state and a test state.
// An insert moves the entries from the given position to the end up by one, a
// delete moves the entries after the given position down by one, and a locate
// reads entries in order until a match or the last entry; a rejected or unused
// opcode, or a locate on an empty list, goes straight to the response.
// The request side opens again in the cycle in which the new response first shows valid.
// A waiting response does not block the next request; if it is still stalled
// when the next result is ready, the block holds that result and waits.
// Reset empties the list and drops any response; entry storage is not cleared.
module ordered_list_insert_delete_top import olid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type ctl;
   sts_type sts;

   olid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   olid_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = !ctl.req_open;

`ifndef NO_ASSERTIONS
   // An accepted operation keeps the request side closed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while an operation was still running");

   // A result is only loaded when the output register is free or being emptied.
   assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_EMIT) |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten before transfer");

   // A removed value only accompanies a successful operation.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.removed_value != 8'd0)) |-> (rsp_data.status == ST_OK))
      else $error("removed value reported with a failing status");

   // A found position only accompanies a successful operation.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_NOT_FOUND)) |-> (rsp_data.found_position == 8'd0))
      else $error("found position reported on a failed search");
`endif

endmodule
